// ===== rtl/core/hsi2rgb_pkg.sv =====
// Shared constants, types and the hue ratio table for the HSI to RGB converter.
package hsi2rgb_pkg;

  localparam int HUE_STEPS    = 8;                 // hue steps per degree
  localparam int SECTOR_STEPS = 120 * HUE_STEPS;
  localparam int FULL_STEPS   = 360 * HUE_STEPS;
  localparam int X_W          = $clog2(SECTOR_STEPS);
  localparam int HUE_W        = 12;
  localparam int SI_W         = 9;                 // saturation and intensity, Q1.8
  localparam int K_W          = 16;                // ratio, signed Q2.14
  localparam int CHAN_BITS    = 8;
  localparam int VW           = 38;                // channel value, signed Q30
  localparam int Q_SHIFT      = 30;
  localparam int K_FRAC       = 14;
  localparam int ONE_SH       = 22;                // 1.0 in Q8.14 product units

  localparam longint Q28_ONE = 64'sd268435456;
  localparam longint PI_Q28  = 64'sd843314857;

  typedef enum logic [1:0] {
    SEC_RED_GREEN,   // blue = A, red = C, green = rest
    SEC_GREEN_BLUE,  // red = A, green = C, blue = rest
    SEC_BLUE_RED     // green = A, blue = C, red = rest
  } sector_t;

  typedef struct packed {
    sector_t             sector;
    logic [X_W-1:0]      x;
    logic [SI_W-1:0]     saturation;
    logic [SI_W-1:0]     intensity;
  } sect_t;

  typedef struct packed {
    sector_t             sector;
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] c;
    logic signed [VW-1:0] rest;
  } mix_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
    logic                 clipped;
  } rgb_t;

  typedef logic signed [K_W-1:0] ratio_rom_t [SECTOR_STEPS];

  // signed quotient truncated toward zero, shift and subtract; table build only
  function automatic longint trunc_div(longint n, longint d);
    longint un;
    longint ud;
    longint rem;
    longint quo;
    logic   neg;
    neg = (n < 0) ^ (d < 0);
    un  = (n < 0) ? -n : n;
    ud  = (d < 0) ? -d : d;
    rem = 0;
    quo = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem << 1) | ((un >> b) & longint'(1));
      if (rem >= ud) begin
        rem = rem - ud;
        quo = quo | (longint'(1) << b);
      end
    end
    return neg ? -quo : quo;
  endfunction

  // cosine of an angle in hue steps, Q28, eleven-term series
  function automatic longint cos_steps(longint steps);
    longint theta;
    longint x2;
    longint term;
    longint sum;
    longint k;
    theta = (steps * PI_Q28 + 90 * HUE_STEPS) / (180 * HUE_STEPS);
    x2    = theta * theta / Q28_ONE;
    term  = Q28_ONE;
    sum   = Q28_ONE;
    for (k = 1; k <= 10; k++) begin
      term = trunc_div(-(term * x2 / Q28_ONE), (2 * k - 1) * (2 * k));
      sum  = sum + term;
    end
    return sum;
  endfunction

  // cos(x)/cos(60-x) in Q2.14, rounded half away from zero, saturated
  function automatic ratio_rom_t build_ratio_rom();
    ratio_rom_t rom;
    longint num;
    longint den;
    longint d;
    longint q;
    for (int x = 0; x < SECTOR_STEPS; x++) begin
      num = cos_steps(longint'(x));
      d   = longint'(60 * HUE_STEPS) - longint'(x);
      den = cos_steps((d < 0) ? -d : d);
      if (den <= 0) begin
        den = 1;
      end
      if (num >= 0) begin
        q = trunc_div(num * 32768 + den, 2 * den);
      end else begin
        q = -trunc_div(-num * 32768 + den, 2 * den);
      end
      if (q > 32767) begin
        q = 32767;
      end
      if (q < -32768) begin
        q = -32768;
      end
      rom[x] = K_W'(q);
    end
    return rom;
  endfunction

endpackage

// ===== rtl/core/hsi2rgb_if.sv =====
// Stream channels of the converter: HSI items in, RGB items out.
interface hsi2rgb_hsi_if import hsi2rgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SI_W-1:0]  saturation;
  logic [SI_W-1:0]  intensity;

  modport source (output valid, hue, saturation, intensity, input ready);
  modport sink   (input valid, hue, saturation, intensity, output ready);
endinterface

interface hsi2rgb_rgb_if import hsi2rgb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAN_BITS-1:0] red;
  logic [CHAN_BITS-1:0] green;
  logic [CHAN_BITS-1:0] blue;
  logic                 clipped;

  modport source (output valid, red, green, blue, clipped, input ready);
  modport sink   (input valid, red, green, blue, clipped, output ready);
endinterface

// ===== rtl/core/hsi2rgb_sector.sv =====
// First stage: hue wrap, sector select and offset within the sector.
module hsi2rgb_sector import hsi2rgb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [HUE_W-1:0] hue,
  input  logic [SI_W-1:0]  saturation,
  input  logic [SI_W-1:0]  intensity,
  output logic             out_valid,
  input  logic             out_ready,
  output sect_t            out
);

  logic [HUE_W-1:0] hue_w;
  sect_t            nxt;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    hue_w = (hue >= HUE_W'(FULL_STEPS)) ? hue - HUE_W'(FULL_STEPS) : hue;
    nxt.saturation = saturation;
    nxt.intensity  = intensity;
    if (hue_w < HUE_W'(SECTOR_STEPS)) begin
      nxt.sector = SEC_RED_GREEN;
      nxt.x      = X_W'(hue_w);
    end else if (hue_w < HUE_W'(2 * SECTOR_STEPS)) begin
      nxt.sector = SEC_GREEN_BLUE;
      nxt.x      = X_W'(hue_w - HUE_W'(SECTOR_STEPS));
    end else begin
      nxt.sector = SEC_BLUE_RED;
      nxt.x      = X_W'(hue_w - HUE_W'(2 * SECTOR_STEPS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out <= nxt;
    end
  end

endmodule

// ===== rtl/core/hsi2rgb_mix.sv =====
// Four stages: ratio ROM read, products, and the three channel values in Q30.
module hsi2rgb_mix import hsi2rgb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  sect_t in,
  output logic  out_valid,
  input  logic  out_ready,
  output mix_t  out
);

  localparam int IP_W = 2 * (SI_W + 1);
  localparam int SK_W = SI_W + 1 + K_W;
  localparam ratio_rom_t RATIO_ROM = build_ratio_rom();
  localparam logic signed [SK_W-1:0] ONE_Q = SK_W'(longint'(1) << ONE_SH);

  logic [3:0] v;
  logic [3:0] en;

  // stage 1
  sector_t                sec1;
  logic [SI_W-1:0]        s1;
  logic [SI_W-1:0]        i1;
  logic signed [K_W-1:0]  k1;
  logic signed [IP_W-1:0] ip1;
  // stage 2
  sector_t                sec2;
  logic [SI_W-1:0]        i2;
  logic signed [IP_W-1:0] ip2;
  logic signed [SK_W-1:0] sk2;
  // stage 3
  sector_t                sec3;
  logic signed [VW-1:0]   a3;
  logic signed [VW-1:0]   c3;
  logic signed [VW-1:0]   base3;

  logic signed [SI_W:0]   sneg;
  logic signed [SK_W-1:0] bias;
  logic [SI_W+1:0]        tri_i;

  assign en[3]    = !v[3] || out_ready;
  assign en[2]    = !v[2] || en[3];
  assign en[1]    = !v[1] || en[2];
  assign en[0]    = !v[0] || en[1];
  assign in_ready = en[0];
  assign out_valid = v[3];

  assign sneg  = (SI_W+1)'(256) - $signed({1'b0, in.saturation});
  assign bias  = ONE_Q + sk2;
  assign tri_i = {1'b0, i2, 1'b0} + {2'b00, i2};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
    end
    if (en[0]) begin
      k1   <= RATIO_ROM[in.x];
      ip1  <= $signed({1'b0, in.intensity}) * sneg;
      sec1 <= in.sector;
      s1   <= in.saturation;
      i1   <= in.intensity;
    end
    if (en[1]) begin
      sk2  <= $signed({1'b0, s1}) * k1;
      sec2 <= sec1;
      i2   <= i1;
      ip2  <= ip1;
    end
    if (en[2]) begin
      c3    <= $signed({1'b0, i2}) * bias;
      a3    <= VW'(ip2) <<< K_FRAC;
      base3 <= $signed({{(VW-SI_W-2-ONE_SH){1'b0}}, tri_i, {ONE_SH{1'b0}}})
               - (VW'(ip2) <<< K_FRAC);
      sec3  <= sec2;
    end
    if (en[3]) begin
      out.rest   <= base3 - c3;
      out.a      <= a3;
      out.c      <= c3;
      out.sector <= sec3;
    end
  end

  // offset must already be inside one sector when the ROM is addressed
  assert property (@(posedge clk) disable iff (rst)
    in_valid |-> in.x < X_W'(SECTOR_STEPS))
    else $error("sector offset out of ROM range");

  // a stalled final stage keeps its values
  assert property (@(posedge clk) disable iff (rst)
    v[3] && !out_ready |=> v[3] && $stable(out.rest) && $stable(out.c))
    else $error("mix output changed under stall");

  // an item taken into the pipe is held in the first stage next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted item lost at stage one");

endmodule

// ===== rtl/core/hsi2rgb_sat.sv =====
// Last stage: scale to channel range, saturate, route A/C/rest to R/G/B.
module hsi2rgb_sat import hsi2rgb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  mix_t in,
  output logic out_valid,
  input  logic out_ready,
  output rgb_t out
);

  typedef struct packed {
    logic [CHAN_BITS-1:0] value;
    logic                 clip;
  } chan_t;

  // floor(MAX * v / 2^30), saturated
  function automatic chan_t to_chan(logic signed [VW-1:0] v);
    logic [VW+CHAN_BITS-1:0] p;
    chan_t                   r;
    p = {v, {CHAN_BITS{1'b0}}} - {{CHAN_BITS{1'b0}}, v};
    if (v[VW-1]) begin
      r.value = '0;
      r.clip  = 1'b1;
    end else if (|p[VW+CHAN_BITS-1:Q_SHIFT+CHAN_BITS]) begin
      r.value = '1;
      r.clip  = 1'b1;
    end else begin
      r.value = p[Q_SHIFT +: CHAN_BITS];
      r.clip  = 1'b0;
    end
    return r;
  endfunction

  chan_t ca;
  chan_t cc;
  chan_t cr;
  rgb_t  nxt;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    ca = to_chan(in.a);
    cc = to_chan(in.c);
    cr = to_chan(in.rest);
    nxt.clipped = ca.clip | cc.clip | cr.clip;
    case (in.sector)
      SEC_RED_GREEN: begin
        nxt.blue  = ca.value;
        nxt.red   = cc.value;
        nxt.green = cr.value;
      end
      SEC_GREEN_BLUE: begin
        nxt.red   = ca.value;
        nxt.green = cc.value;
        nxt.blue  = cr.value;
      end
      SEC_BLUE_RED: begin
        nxt.green = ca.value;
        nxt.blue  = cc.value;
        nxt.red   = cr.value;
      end
      default: begin
        nxt.red   = '0;
        nxt.green = '0;
        nxt.blue  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out <= nxt;
    end
  end

endmodule

// ===== rtl/core/hsi_to_rgb_converter.sv =====
// Top level of the HSI to RGB pixel converter.
// Converts one pixel per item from hue (eighths of a degree), saturation and
// intensity (Q1.8, 256 = 1.0) to 8-bit red, green and blue using the
// three-sector HSI formulas; clipped reports that any channel was saturated.
// Hue at or above 2880 wraps by 2880. Throughput is one item per clock when
// the output does not stall. Each item passes through six register stages
// before its result is presented: one for hue wrap and sector select,
// four for the ratio ROM read and the products, one for scaling and
// saturation. Each stage has its own valid bit
// and loads whenever it is empty or the stage after it moves, so bubbles
// collapse and a stall on the output backs up stage by stage without
// dropping or repeating an item. The cos(x)/cos(60-x) ratio lives in a
// 960-entry Q2.14 ROM built at elaboration and read through a register; it
// needs no loading after reset.
module hsi_to_rgb_converter import hsi2rgb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  hsi2rgb_hsi_if.sink          hsi,
  hsi2rgb_rgb_if.source        rgb
);

  // front -> mix
  logic  sect_valid;
  logic  sect_ready;
  sect_t sect;

  // mix -> saturation
  logic  mix_valid;
  logic  mix_ready;
  mix_t  mix;

  rgb_t  px;

  hsi2rgb_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (hsi.valid),
    .in_ready   (hsi.ready),
    .hue        (hsi.hue),
    .saturation (hsi.saturation),
    .intensity  (hsi.intensity),
    .out_valid  (sect_valid),
    .out_ready  (sect_ready),
    .out        (sect)
  );

  hsi2rgb_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sect_valid),
    .in_ready  (sect_ready),
    .in        (sect),
    .out_valid (mix_valid),
    .out_ready (mix_ready),
    .out       (mix)
  );

  hsi2rgb_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in        (mix),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .out       (px)
  );

  // result register drives the output channel directly
  assign rgb.red     = px.red;
  assign rgb.green   = px.green;
  assign rgb.blue    = px.blue;
  assign rgb.clipped = px.clipped;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the HSI to RGB pixel converter: random and corner pixels, stalls.
module testbench;
  import hsi2rgb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Hand-written prediction: the ratio table is rebuilt here from the cosine
  // series, then each accepted pixel is converted in 64-bit integer math.
  localparam longint CHAN_MAX   = (longint'(1) << CHAN_BITS) - 1;
  localparam int     QUIET_TAIL = 150;   // items left when idling stops
  localparam int     RANDOM_PIX = 1250;
  localparam int     LONG_HOLD  = 150;   // hold count of the one long output stall
  localparam int     HOLD_AT    = 400;   // results seen before the long stall

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [SI_W-1:0]  saturation;
    logic [SI_W-1:0]  intensity;
  } hsi_item_t;

  logic clk = 1'b0;
  logic rst;

  hsi2rgb_hsi_if hsi ();
  hsi2rgb_rgb_if rgb ();

  hsi_to_rgb_converter i_dut (
    .clk (clk),
    .rst (rst),
    .hsi (hsi),
    .rgb (rgb)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic signed [K_W-1:0] ratio_tbl [SECTOR_STEPS];
  hsi_item_t             pixel_queue[$];      // items not yet offered
  rgb_t                  expected_pixels[$];  // predicted results, oldest first
  int                    fault_count  = 0;
  int                    pixels_seen  = 0;
  int                    idle_left    = 0;
  int                    hold_left    = 0;
  bit                    long_hold_done = 1'b0;

  // Q28 cosine of an angle in hue steps, truncating eleven-term Taylor series
  function automatic longint cos_q28(longint steps);
    longint theta, sq, term, acc;
    theta = (steps * PI_Q28 + 90 * HUE_STEPS) / (180 * HUE_STEPS);
    sq    = theta * theta / Q28_ONE;
    term  = Q28_ONE;
    acc   = Q28_ONE;
    for (int n = 1; n <= 10; n++) begin
      term = -(term * sq / Q28_ONE) / ((2 * n - 1) * (2 * n));
      acc += term;
    end
    return acc;
  endfunction

  // cos(x)/cos(60-x) in Q2.14, rounded half away from zero; x = 0 saturates
  task automatic build_ratio_table();
    longint num, den, span, q;
    for (int x = 0; x < SECTOR_STEPS; x++) begin
      num  = cos_q28(x);
      span = 60 * HUE_STEPS - x;
      den  = cos_q28(span < 0 ? -span : span);
      if (den <= 0) den = 1;
      if (num >= 0) q = (num * 32768 + den) / (2 * den);
      else          q = -((-num * 32768 + den) / (2 * den));
      if (q > 32767)  q = 32767;
      if (q < -32768) q = -32768;
      ratio_tbl[x] = K_W'(q);
    end
  endtask

  // floor(MAXC * v / 2^30), saturated; MSB of the result is the clip flag
  function automatic logic [CHAN_BITS:0] scale_channel(longint v);
    longint q;
    if (v < 0) return {1'b1, {CHAN_BITS{1'b0}}};
    q = (CHAN_MAX * v) >>> Q_SHIFT;
    if (q > CHAN_MAX) return {1'b1, CHAN_BITS'(CHAN_MAX)};
    return {1'b0, q[CHAN_BITS-1:0]};
  endfunction

  function automatic rgb_t predict_pixel(hsi_item_t px);
    longint h, s, i, x, k, a, c, rest;
    sector_t sec;
    logic [CHAN_BITS:0] ch_a, ch_c, ch_r;
    rgb_t out;
    h    = longint'(px.hue) % FULL_STEPS;   // out-of-range hue wraps
    s    = longint'(px.saturation);
    i    = longint'(px.intensity);
    sec  = sector_t'(h / SECTOR_STEPS);
    x    = h % SECTOR_STEPS;
    k    = longint'(ratio_tbl[x]);
    a    = i * (256 - s) * 16384;            // goes negative for s above 1.0
    c    = i * ((longint'(1) << ONE_SH) + s * k);
    rest = 3 * i * (longint'(1) << ONE_SH) - a - c;
    ch_a = scale_channel(a);
    ch_c = scale_channel(c);
    ch_r = scale_channel(rest);
    out  = '0;
    case (sec)
      SEC_RED_GREEN: begin
        out.blue = ch_a[CHAN_BITS-1:0]; out.red = ch_c[CHAN_BITS-1:0];
        out.green = ch_r[CHAN_BITS-1:0];
      end
      SEC_GREEN_BLUE: begin
        out.red = ch_a[CHAN_BITS-1:0]; out.green = ch_c[CHAN_BITS-1:0];
        out.blue = ch_r[CHAN_BITS-1:0];
      end
      SEC_BLUE_RED: begin
        out.green = ch_a[CHAN_BITS-1:0]; out.blue = ch_c[CHAN_BITS-1:0];
        out.red = ch_r[CHAN_BITS-1:0];
      end
      default: ;
    endcase
    out.clipped = ch_a[CHAN_BITS] | ch_c[CHAN_BITS] | ch_r[CHAN_BITS];
    return out;
  endfunction

  task automatic add_pixel(int h, int s, int i);
    hsi_item_t it;
    it.hue        = HUE_W'(h);
    it.saturation = SI_W'(s);
    it.intensity  = SI_W'(i);
    pixel_queue.push_back(it);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  // Sender: a new item goes out whenever the slot is free, with random
  // idle bursts after an item until the last QUIET_TAIL items.
  always @(posedge clk) begin
    hsi_item_t nxt;
    if (rst) begin
      hsi.valid <= 1'b0;
    end else if (!hsi.valid || hsi.ready) begin
      if (idle_left > 0) begin
        hsi.valid <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pixel_queue.size() > 0) begin
        nxt = pixel_queue.pop_front();
        hsi.valid      <= 1'b1;
        hsi.hue        <= nxt.hue;
        hsi.saturation <= nxt.saturation;
        hsi.intensity  <= nxt.intensity;
        if (pixel_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
          idle_left <= $urandom_range(1, 17);
        end
      end else begin
        hsi.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off so the pipeline
  // fills and pushes back on the input while the sender keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      rgb.ready <= 1'b0;
      hold_left <= 0;
    end else if (!long_hold_done && pixels_seen >= HOLD_AT) begin
      rgb.ready      <= 1'b0;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      rgb.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (pixel_queue.size() < QUIET_TAIL) begin
      rgb.ready <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      rgb.ready <= 1'b0;
      hold_left <= $urandom_range(0, 16);
    end else begin
      rgb.ready <= 1'b1;
    end
  end

  // Input side: every accepted pixel gets its expected color queued.
  always @(posedge clk) begin
    hsi_item_t got;
    if (!rst && hsi.valid && hsi.ready) begin
      got.hue        = hsi.hue;
      got.saturation = hsi.saturation;
      got.intensity  = hsi.intensity;
      expected_pixels.push_back(predict_pixel(got));
    end
  end

  // Output side: each accepted result against the oldest prediction.
  always @(posedge clk) begin
    rgb_t want;
    if (!rst && rgb.valid && rgb.ready) begin
      pixels_seen <= pixels_seen + 1;
      if (expected_pixels.size() == 0) begin
        $error("result with no pixel pending: r=%0d g=%0d b=%0d", rgb.red, rgb.green,
               rgb.blue);
        fault_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", want.red, rgb.red);
        check_field("green", want.green, rgb.green);
        check_field("blue", want.blue, rgb.blue);
        check_field("clipped", want.clipped, rgb.clipped);
      end
    end
  end

  initial begin
    int edges[12];
    int pick;
    rst            = 1'b1;
    hsi.valid      = 1'b0;
    hsi.hue        = '0;
    hsi.saturation = '0;
    hsi.intensity  = '0;
    rgb.ready      = 1'b0;
    edges = '{0, 1, 479, 480, 481, 959, 960, 961, 1919, 1920, 2879, 2880};
    build_ratio_table();

    // corners: black, gray, full colors at sector starts, ends and middles
    add_pixel(0, 0, 0);
    add_pixel(0, 0, 256);
    add_pixel(0, 256, 256);      // saturated table entry at x = 0
    add_pixel(480, 256, 256);
    add_pixel(700, 256, 128);
    add_pixel(959, 256, 256);
    add_pixel(960, 256, 256);
    add_pixel(961, 128, 200);
    add_pixel(1440, 256, 256);
    add_pixel(1919, 256, 256);
    add_pixel(1920, 256, 256);
    add_pixel(2400, 256, 256);
    add_pixel(2879, 256, 256);
    add_pixel(2880, 128, 128);   // hue wraps to zero
    add_pixel(3840, 100, 200);   // wraps into the second sector
    add_pixel(4095, 511, 511);   // all inputs high
    add_pixel(0, 511, 256);      // saturation above 1.0, negative channel
    add_pixel(960, 511, 128);
    add_pixel(200, 256, 511);    // intensity above 1.0, clips high
    add_pixel(1500, 0, 511);
    add_pixel(2000, 300, 300);
    add_pixel(100, 128, 0);
    add_pixel(0, 256, 255);
    add_pixel(2000, 1, 1);

    for (int n = 0; n < RANDOM_PIX; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        add_pixel($urandom_range(0, FULL_STEPS - 1), $urandom_range(0, 256),
                  $urandom_range(0, 256));
      end else if (pick == 7) begin
        add_pixel(edges[$urandom_range(0, 11)], $urandom_range(0, 256),
                  $urandom_range(0, 256));
      end else if (pick == 8) begin
        add_pixel($urandom_range(0, FULL_STEPS - 1), $urandom_range(0, 1) * 256,
                  $urandom_range(0, 1) * 256);
      end else begin
        add_pixel($urandom_range(0, 4095), $urandom_range(0, 511), $urandom_range(0, 511));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drain: all items offered and taken, every prediction matched
    while (pixel_queue.size() != 0 || hsi.valid || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (12) @(posedge clk);

    if (fault_count == 0 && expected_pixels.size() == 0) begin
      $display("[hsi_to_rgb_converter] OK");
    end else begin
      $display("[hsi_to_rgb_converter] ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[hsi_to_rgb_converter] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hsi2rgb_pkg.sv
rtl/core/hsi2rgb_if.sv
rtl/core/hsi2rgb_sector.sv
rtl/core/hsi2rgb_mix.sv
rtl/core/hsi2rgb_sat.sv
rtl/core/hsi_to_rgb_converter.sv
bench/testbench.sv
